// ----- rtl/ihex_pkg.sv -----
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared widths, codes and types of the hex record loader.
// ----------------------------------------------------------------------------
package ihex_pkg;

  localparam int ADDR_BITS = 16;

  // result kinds
  localparam logic RESULT_WRITE = 1'b0;
  localparam logic RESULT_END   = 1'b1;

  // one result leaving the parser
  typedef struct packed {
    logic                 valid;
    logic                 kind;
    logic [ADDR_BITS-1:0] addr;
    logic [7:0]           data;
  } result_t;

  // parser status seen by the top level
  typedef struct packed {
    logic finished;
  } status_t;

endpackage

// ----- rtl/ihex_parse.sv -----
// ----------------------------------------------------------------------------
// ihex_parse
// Record parser: holds the parse state and turns one character into at most
// one result.
// ----------------------------------------------------------------------------
module ihex_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          char_in,
  output ihex_pkg::result_t   res,
  output ihex_pkg::status_t   status
);

  typedef enum logic [3:0] {
    PH_WAIT_COLON = 4'd0,
    PH_COUNT      = 4'd1,
    PH_ADDR_HI    = 4'd2,
    PH_ADDR_LO    = 4'd3,
    PH_TYPE       = 4'd4,
    PH_DATA       = 4'd5,
    PH_CHECKSUM   = 4'd6,
    PH_SKIP_LINE  = 4'd7
  } phase_t;

  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] KIND_DATA  = 8'h00;
  localparam logic [7:0] KIND_END   = 8'h01;

  // hex digit value, anything else reads as zero
  function automatic logic [3:0] nibble_of(input logic [7:0] ch);
    logic [3:0] v;
    v = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) v = 4'(ch - 8'h30);
    else if (ch >= 8'h41 && ch <= 8'h46) v = 4'(ch - 8'h37);
    else if (ch >= 8'h61 && ch <= 8'h66) v = 4'(ch - 8'h57);
    return v;
  endfunction

  phase_t                         phase_r, phase_nxt;
  logic                           second_r, second_nxt;
  logic [3:0]                     nib_r, nib_nxt;
  logic [7:0]                     left_r, left_nxt;
  logic [ihex_pkg::ADDR_BITS-1:0] addr_r, addr_nxt;
  logic                           fin_r, fin_nxt;
  logic [7:0]                     byte_val;

  assign byte_val = {nib_r, nibble_of(char_in)};

  always_comb begin
    phase_nxt  = phase_r;
    second_nxt = second_r;
    nib_nxt    = nib_r;
    left_nxt   = left_r;
    addr_nxt   = addr_r;
    fin_nxt    = fin_r;
    res        = '0;
    if (!fin_r) begin
      case (phase_r)
        PH_WAIT_COLON: begin
          if (char_in == CHAR_COLON) begin
            phase_nxt  = PH_COUNT;
            second_nxt = 1'b0;
            nib_nxt    = 4'd0;
          end
        end
        PH_SKIP_LINE: begin
          if (char_in == CHAR_CR || char_in == CHAR_LF) phase_nxt = PH_WAIT_COLON;
        end
        PH_COUNT, PH_ADDR_HI, PH_ADDR_LO, PH_TYPE, PH_DATA, PH_CHECKSUM: begin
          if (!second_r) begin
            nib_nxt    = nibble_of(char_in);
            second_nxt = 1'b1;
          end else begin
            second_nxt = 1'b0;
            nib_nxt    = 4'd0;
            case (phase_r)
              PH_COUNT: begin
                left_nxt  = byte_val;
                phase_nxt = PH_ADDR_HI;
              end
              PH_ADDR_HI: begin
                addr_nxt  = {byte_val, addr_r[7:0] & 8'h00};
                phase_nxt = PH_ADDR_LO;
              end
              PH_ADDR_LO: begin
                addr_nxt  = {addr_r[ihex_pkg::ADDR_BITS-1:8], byte_val};
                phase_nxt = PH_TYPE;
              end
              PH_TYPE: begin
                if (byte_val == KIND_DATA) begin
                  phase_nxt = (left_r != 8'd0) ? PH_DATA : PH_CHECKSUM;
                end else if (byte_val == KIND_END) begin
                  fin_nxt   = 1'b1;
                  phase_nxt = PH_WAIT_COLON;
                  res.valid = 1'b1;
                  res.kind  = ihex_pkg::RESULT_END;
                end else begin
                  phase_nxt = PH_SKIP_LINE;
                end
              end
              PH_DATA: begin
                res.valid = 1'b1;
                res.kind  = ihex_pkg::RESULT_WRITE;
                res.addr  = addr_r;
                res.data  = byte_val;
                addr_nxt  = addr_r + 1'b1;
                left_nxt  = left_r - 8'd1;
                if (left_r == 8'd1) phase_nxt = PH_CHECKSUM;
              end
              default: begin
                phase_nxt = PH_WAIT_COLON;
              end
            endcase
          end
        end
        default: begin
          phase_nxt = PH_WAIT_COLON;
        end
      endcase
    end
  end

  assign status.finished = fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT_COLON;
      second_r <= 1'b0;
      nib_r    <= 4'd0;
      left_r   <= 8'd0;
      addr_r   <= '0;
      fin_r    <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      second_r <= second_nxt;
      nib_r    <= nib_nxt;
      left_r   <= left_nxt;
      addr_r   <= addr_nxt;
      fin_r    <= fin_nxt;
    end
  end

endmodule

// ----- rtl/intel_hex_record_loader.sv -----
// ----------------------------------------------------------------------------
// intel_hex_record_loader
// Parses a stream of hex file characters into memory write requests and an
// end-of-file indication.
// ----------------------------------------------------------------------------
//
//   channel   direction   ports                                    carries
//   input     in          in_valid, in_ready, in_char_in           one character
//   result    out         out_valid, out_ready, out_result_kind,   write request
//                         out_write_address, out_write_data        or end marker
//
// one character per cycle sustained unless a result waits on a stalled output;
// a character is held in the input register, is parsed there and its result
// (if any) lands in the output register, which drives out_valid once the
// last digit of a data byte has been parsed
// reset is synchronous, active low, and clears the parser to waiting for a colon
// a stalled result only blocks a character that itself makes a result;
// characters that make none keep flowing past the waiting output register
// after the end record every character is taken and dropped until reset
module intel_hex_record_loader (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_char_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_result_kind,
  output logic [ihex_pkg::ADDR_BITS-1:0] out_write_address,
  output logic [7:0]                     out_write_data
);

  // input register
  logic                in_valid_r;
  logic [7:0]          in_char_r;

  // output register
  logic                           out_valid_r;
  logic                           out_kind_r;
  logic [ihex_pkg::ADDR_BITS-1:0] out_addr_r;
  logic [7:0]                     out_data_r;

  ihex_pkg::result_t res;
  ihex_pkg::status_t status;
  logic              out_free;
  logic              fire;

  ihex_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (fire),
    .char_in (in_char_r),
    .res     (res),
    .status  (status)
  );

  // output slot is free if empty or drained this cycle
  assign out_free = !out_valid_r || out_ready;
  // the held character is parsed once its result, if any, has somewhere to go
  assign fire     = in_valid_r && (!res.valid || out_free);
  assign in_ready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_char_r <= in_char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_kind_r <= res.kind;
      out_addr_r <= res.addr;
      out_data_r <= res.data;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_write_address = out_addr_r;
  assign out_write_data    = out_data_r;

  // end seen stays seen until reset
  a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    status.finished |=> status.finished)
    else $error("finished flag dropped");

  // nothing is produced once the end record is seen
  a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    status.finished |-> !res.valid)
    else $error("result after end record");

  // input stalls only behind a result that cannot leave
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && res.valid && out_valid_r && !out_ready))
    else $error("input stalled without cause");

  // a parsed result always reaches the output register
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.valid) |=> out_valid_r)
    else $error("parsed result lost");

endmodule
